// File: design/median_filter_5x5_rgb_defines.svh
// assertion macros shared by the median filter modules
`ifndef MEDIAN_FILTER_5X5_RGB_DEFINES_SVH
`define MEDIAN_FILTER_5X5_RGB_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// types and constants shared by the 5x5 rgb median filter modules
// ----------------------------------------------------------------------------
`default_nettype none

package mf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int WIN        = 5;
    localparam int HALF       = WIN / 2;
    localparam int TAPS       = WIN * WIN;
    localparam int MED        = (TAPS - 1) / 2;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    typedef logic [23:0] t_pix;
    typedef t_pix [WIN-1:0] t_col;
    typedef t_col [WIN-1:0] t_win;
    typedef t_pix [WIN-2:0] t_line;

    typedef struct packed {
        logic       operation;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [9:0] pixel_col;
        logic [9:0] pixel_row;
        logic       last_of_image;
    } t_out;

    typedef struct packed {
        t_win       win;
        logic [9:0] col;
        logic [9:0] row;
        logic       last;
    } t_job;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } t_qstat;

endpackage

`default_nettype wire

// File: design/mf_ram.sv
// ----------------------------------------------------------------------------
// mf_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/mf_front.sv
// ----------------------------------------------------------------------------
// mf_front
// raster counters, line store and window register; builds masked windows
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_filter_5x5_rgb_defines.svh"

module mf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire mf_pkg::t_in    i_data,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [10:0]    i_cfg_data,
    input  wire mf_pkg::t_qstat i_qstat,
    output logic                o_push,
    output mf_pkg::t_job        o_job
);

    localparam int CW = mf_pkg::COL_W;
    localparam int W  = mf_pkg::WIN;

    logic [10:0]   r_width_reg, r_height_reg;
    logic [CW-1:0] r_in_col;
    logic [10:0]   r_in_row;
    logic [11:0]   r_warm;
    logic [9:0]    r_out_col, r_out_row;

    logic           r_b_valid, r_b_emit, r_b_last;
    mf_pkg::t_pix   r_b_sample;
    logic [CW-1:0]  r_b_addr;
    logic [W-1:0]   r_b_cmask, r_b_rmask;
    logic [9:0]     r_b_col, r_b_row;
    mf_pkg::t_win   r_win;
    logic           r_lw_valid;
    logic [CW-1:0]  r_lw_addr;
    mf_pkg::t_line  r_lw_data;

    logic [10:0]   w_eff, h_eff;
    logic [11:0]   lag;
    logic          accept, emit, last, col_wrap, out_wrap;
    mf_pkg::t_pix  sample;
    logic [W-1:0]  cmask, rmask;
    mf_pkg::t_line ram_rdata, prev, wdata;
    mf_pkg::t_col  col_new;
    mf_pkg::t_win  n_win;

    // register values outside the legal range are clamped
    always_comb begin
        if (r_width_reg == 11'd0) begin
            w_eff = 11'd1;
        end else if (r_width_reg > 11'(mf_pkg::MAX_WIDTH)) begin
            w_eff = 11'(mf_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_width_reg;
        end
        if (r_height_reg == 11'd0) begin
            h_eff = 11'd1;
        end else if (r_height_reg > 11'(mf_pkg::MAX_HEIGHT)) begin
            h_eff = 11'(mf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_height_reg;
        end
    end

    assign lag     = 12'(mf_pkg::HALF * int'(w_eff) + mf_pkg::HALF);
    // credit for the item still in the window stage
    assign o_stall = (int'(i_qstat.count) + int'(r_b_valid)) >= mf_pkg::QDEPTH;
    assign accept  = i_valid && !o_stall;
    assign emit    = (r_warm == lag);
    assign last    = emit && ({1'b0, r_out_row} == h_eff - 11'd1)
                          && ({1'b0, r_out_col} == w_eff - 11'd1);
    assign col_wrap = (11'({1'b0, r_in_col}) + 11'd1) >= w_eff;
    assign out_wrap = (11'({1'b0, r_out_col}) + 11'd1) >= w_eff;

    // flush items and pixels past the image end store zero
    assign sample = (r_in_row < h_eff && !i_data.operation) ?
                    {i_data.red_in, i_data.green_in, i_data.blue_in} : '0;

    // which window columns and rows fall inside the image
    always_comb begin
        int c;
        int r;
        for (int a = 0; a < W; a++) begin
            c = int'(r_out_col) + mf_pkg::HALF - a;
            r = int'(r_out_row) + mf_pkg::HALF - a;
            cmask[a] = (c >= 0) && (c < int'(w_eff));
            rmask[a] = (r >= 0) && (r < int'(h_eff));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_reg  <= 11'd640;
            r_height_reg <= 11'd480;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_warm       <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == mf_pkg::REG_WIDTH) begin
                r_width_reg <= i_cfg_data;
            end
            if (i_cfg_index == mf_pkg::REG_HEIGHT) begin
                r_height_reg <= i_cfg_data;
            end
            if (i_cfg_index == mf_pkg::REG_WIDTH || i_cfg_index == mf_pkg::REG_HEIGHT) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_warm    <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end
        end else if (accept) begin
            if (last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_warm    <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 11'd1;
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (!emit) begin
                    r_warm <= r_warm + 12'd1;
                end else if (out_wrap) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 10'd1;
                end else begin
                    r_out_col <= r_out_col + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
        end
        if (accept) begin
            r_b_emit   <= emit;
            r_b_last   <= last;
            r_b_sample <= sample;
            r_b_addr   <= r_in_col;
            r_b_cmask  <= cmask;
            r_b_rmask  <= rmask;
            r_b_col    <= r_out_col;
            r_b_row    <= r_out_row;
        end
    end

    // line store: one word per column holding the four rows above
    mf_ram #(
        .WIDTH($bits(mf_pkg::t_line)),
        .DEPTH(mf_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (r_b_valid),
        .i_waddr(r_b_addr),
        .i_wdata(wdata),
        .i_raddr(r_in_col),
        .o_rdata(ram_rdata)
    );

    // forward the last write when the same column comes straight back
    assign prev = (r_lw_valid && r_lw_addr == r_b_addr) ? r_lw_data : ram_rdata;

    always_comb begin
        col_new[0] = r_b_sample;
        for (int k = 1; k < W; k++) begin
            col_new[k] = prev[k-1];
        end
        for (int k = 0; k < W - 1; k++) begin
            wdata[k] = col_new[k];
        end
        n_win[0] = col_new;
        for (int a = 1; a < W; a++) begin
            n_win[a] = r_win[a-1];
        end
        for (int a = 0; a < W; a++) begin
            for (int k = 0; k < W; k++) begin
                o_job.win[a][k] = (r_b_cmask[a] && r_b_rmask[k]) ? n_win[a][k] : '0;
            end
        end
        o_job.col  = r_b_col;
        o_job.row  = r_b_row;
        o_job.last = r_b_last;
    end

    assign o_push = r_b_valid && r_b_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_valid <= 1'b0;
        end else if (r_b_valid) begin
            r_lw_valid <= 1'b1;
        end
        if (r_b_valid) begin
            r_win     <= n_win;
            r_lw_addr <= r_b_addr;
            r_lw_data <= wdata;
        end
    end

    `MF_ASSERT_IMP(a_warm_bound, 1'b1, r_warm <= lag, "warm-up count passed the lag")
    `MF_ASSERT_IMP(a_out_col_bound, 1'b1, {1'b0, r_out_col} < w_eff, "output column out of row")

endmodule

`default_nettype wire

// File: design/mf_queue.sv
// ----------------------------------------------------------------------------
// mf_queue
// short queue of masked windows between window builder and sorter
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_filter_5x5_rgb_defines.svh"

module mf_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire mf_pkg::t_job   i_job,
    input  wire logic           i_pop,
    output mf_pkg::t_job        o_job,
    output mf_pkg::t_qstat      o_qstat
);

    mf_pkg::t_job                r_mem [mf_pkg::QDEPTH];
    logic [mf_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [mf_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + mf_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + mf_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + mf_pkg::QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - mf_pkg::QCNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job         = r_mem[r_rp];
    assign o_qstat.count = r_count;
    assign o_qstat.empty = (r_count == '0);

    `MF_ASSERT_IMP(a_no_overflow, i_push, r_count < mf_pkg::QCNT_W'(mf_pkg::QDEPTH),
        "push into full queue")
    `MF_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `MF_ASSERT_NXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1,
        "queue count did not follow a push")

endmodule

`default_nettype wire

// File: design/mf_back.sv
// ----------------------------------------------------------------------------
// mf_back
// rank-based median of 25 samples per channel, three pipeline stages
// ----------------------------------------------------------------------------
`default_nettype none

`include "median_filter_5x5_rgb_defines.svh"

module mf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire mf_pkg::t_qstat i_qstat,
    input  wire mf_pkg::t_job   i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output mf_pkg::t_out        o_data
);

    localparam int T = mf_pkg::TAPS;
    localparam int W = mf_pkg::WIN;

    logic                           adv;
    logic                           r_v1, r_v2, r_v3;
    mf_pkg::t_job                   r_job1, r_job2;
    logic [2:0][T-1:0][T-1:0]       lt, r_lt1;
    logic [2:0][T-1:0]              sel, r_sel2;
    logic [2:0][T-1:0][7:0]         tap_in, tap2;
    logic [2:0][7:0]                med;
    mf_pkg::t_out                   r_out;

    // channel samples of each tap, red first
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int a = 0; a < W; a++) begin
                for (int k = 0; k < W; k++) begin
                    tap_in[ch][a*W+k] = i_job.win[a][k][(2-ch)*8 +: 8];
                    tap2[ch][a*W+k]   = r_job2.win[a][k][(2-ch)*8 +: 8];
                end
            end
        end
    end

    // tie-break on index so every tap gets a distinct rank
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < T; i++) begin
                for (int j = 0; j < T; j++) begin
                    lt[ch][i][j] = (tap_in[ch][j] < tap_in[ch][i]) ||
                                   ((tap_in[ch][j] == tap_in[ch][i]) && (j < i));
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < T; i++) begin
                sel[ch][i] = ($countones(r_lt1[ch][i]) == mf_pkg::MED);
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            med[ch] = '0;
            for (int i = 0; i < T; i++) begin
                med[ch] = med[ch] | (r_sel2[ch][i] ? tap2[ch][i] : 8'd0);
            end
        end
    end

    assign adv   = !r_v3 || !i_stall;
    assign o_pop = adv && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (adv) begin
            r_job1 <= i_job;
            r_lt1  <= lt;
            r_job2 <= r_job1;
            r_sel2 <= sel;
            r_out.red_out       <= med[0];
            r_out.green_out     <= med[1];
            r_out.blue_out      <= med[2];
            r_out.pixel_col     <= r_job2.col;
            r_out.pixel_row     <= r_job2.row;
            r_out.last_of_image <= r_job2.last;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = r_out;

    `MF_ASSERT_IMP(a_one_median_red, r_v2, $onehot(r_sel2[0]), "red median rank not unique")
    `MF_ASSERT_IMP(a_one_median_blue, r_v2, $onehot(r_sel2[2]), "blue median rank not unique")

endmodule

`default_nettype wire

// File: design/median_filter_5x5_rgb.sv
// ----------------------------------------------------------------------------
// median_filter_5x5_rgb
// streaming 5x5 median filter over rgb pixels in raster order
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one filtered pixel per clock in steady
// state when nothing stalls. The line store is read at the edge that accepts
// an item, and the window is shifted and written into a four-entry queue in
// the following cycle. The rank sorter then takes the job from the queue, and
// its two rank stages feed the output register. A result thus passes the
// window stage, the queue, the two rank stages and the output register;
// output stalls and a fuller queue hold it longer. Output lags input by two
// rows and two pixels, so after an image send 2*width+2 flush items. Writing
// either register restarts the image. Outside-image taps count as zero. The
// line store needs no clearing after reset.
`default_nettype none

module median_filter_5x5_rgb (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire mf_pkg::t_in   i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output mf_pkg::t_out       o_data,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [10:0]   i_cfg_data
);

    mf_pkg::t_qstat qstat;
    mf_pkg::t_job   push_job, head_job;
    logic           push, pop;

    mf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    mf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .i_pop  (pop),
        .o_job  (head_job),
        .o_qstat(qstat)
    );

    mf_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_qstat(qstat),
        .i_job  (head_job),
        .o_pop  (pop),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

endmodule

`default_nettype wire
